/* rtl/lec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lec_pkg
// shared types and codes of the look elevator scheduler
// ----------------------------------------------------------------------------
package lec_pkg;

  localparam int FloorW = 5;
  localparam int LoadW  = 4;
  localparam int TimeW  = 32;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_RIDE  = 2'd2;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_START    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_ALIGHT, S_BOARD, S_SCAN, S_DONE
  } lec_state_t;

  typedef enum logic [2:0] {
    PH_NONE, PH_ADD, PH_ALIGHT, PH_BOARD, PH_SCAN
  } lec_phase_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    lec_phase_t          phase;
    logic [FloorW-1:0]   floor;
    logic [FloorW-1:0]   new_origin;
    logic [FloorW-1:0]   new_target;
    logic                can_board;
  } lec_cmd_t;

  // points of interest, or-ed along the chain
  typedef struct packed {
    logic above;
    logic below;
    logic here;
  } lec_interest_t;

endpackage
`default_nettype wire

/* rtl/lec_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lec channel interfaces
// valid/ready channels for input items, result items and configuration
// ----------------------------------------------------------------------------
interface lec_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [4:0] origin_floor;
  logic [4:0] target_floor;
  modport source (output valid, operation, origin_floor, target_floor, input ready);
  modport sink   (input valid, operation, origin_floor, target_floor, output ready);
endinterface

interface lec_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  car_position;
  logic [1:0]  heading;
  logic [3:0]  riders;
  logic        stopped_here;
  logic [31:0] time_units;
  logic        request_dropped;
  modport source (output valid, car_position, heading, riders, stopped_here, time_units,
                  request_dropped, input ready);
  modport sink   (input valid, car_position, heading, riders, stopped_here, time_units,
                  request_dropped, output ready);
endinterface

interface lec_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/lec_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lec_cell
// one passenger slot of the table, linked to its neighbours by chains
// ----------------------------------------------------------------------------
module lec_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lec_pkg::lec_cmd_t      cmd,
  input  wire logic                   empty_seen_in,
  output logic                        empty_seen_out,
  input  wire logic                   board_seen_in,
  output logic                        board_seen_out,
  input  wire lec_pkg::lec_interest_t interest_in,
  output lec_pkg::lec_interest_t      interest_out,
  output logic                        alight,
  output logic                        board_tgt_here,
  output logic                        riding
);
  import lec_pkg::*;

  logic [1:0]        status_r, status_nxt;
  logic [FloorW-1:0] origin_r, target_r;
  logic              is_empty, wait_here, add_me, board_me, poi;
  logic [FloorW-1:0] p;

  always_comb begin
    is_empty       = (status_r == ST_EMPTY);
    wait_here      = (status_r == ST_WAIT) && (origin_r == cmd.floor);
    riding         = (status_r == ST_RIDE);
    alight         = riding && (target_r == cmd.floor);
    add_me         = (cmd.phase == PH_ADD) && is_empty && !empty_seen_in;
    board_me       = (cmd.phase == PH_BOARD) && cmd.can_board && wait_here && !board_seen_in;
    board_tgt_here = board_me && (target_r == cmd.floor);
    empty_seen_out = empty_seen_in | is_empty;
    board_seen_out = board_seen_in | wait_here;
    poi            = riding || ((status_r == ST_WAIT) && cmd.can_board);
    p              = riding ? target_r : origin_r;
    interest_out.above = interest_in.above | (poi && (p > cmd.floor));
    interest_out.below = interest_in.below | (poi && (p < cmd.floor));
    interest_out.here  = interest_in.here  | (poi && (p == cmd.floor));
  end

  always_comb begin
    status_nxt = status_r;
    if (add_me) begin
      status_nxt = ST_WAIT;
    end else if ((cmd.phase == PH_ALIGHT) && alight) begin
      status_nxt = ST_EMPTY;
    end else if (board_me) begin
      status_nxt = (target_r == cmd.floor) ? ST_EMPTY : ST_RIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_EMPTY;
    end else begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (add_me) begin
      origin_r <= cmd.new_origin;
      target_r <= cmd.new_target;
    end
  end

endmodule
`default_nettype wire

/* rtl/look_elevator_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// look_elevator_scheduler
// single-car LOOK elevator over a chain of passenger cells
// ----------------------------------------------------------------------------
// sequence: an add item passes through the add and done states to its result, a tick
// item through alight, board, scan and done; one item is worked on at a time, and
// no new item is taken until the last one has left the done state
// reset: synchronous, active low; all cells empty, car on floor 1, idle,
// capacity 4, no clearing pass
module look_elevator_scheduler #(
  parameter int MAX_PASSENGERS = 64,
  parameter int TOP_FLOOR      = 31
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lec_in_if.sink    in_ch,
  lec_out_if.source out_ch,
  lec_cfg_if.sink   cfg_ch
);
  import lec_pkg::*;

  localparam logic [FloorW-1:0] TopEff = (TOP_FLOOR > 31) ? 5'd31 : FloorW'(TOP_FLOOR);
  localparam int CntW = $clog2(MAX_PASSENGERS + 1);

  lec_state_t        state_r, state_nxt;
  lec_phase_t        phase;
  logic [LoadW-1:0]  cap_r, load_r;
  logic [FloorW-1:0] floor_r, org_r, tgt_r;
  logic [1:0]        dir_r;
  logic [TimeW-1:0]  time_r;
  logic              stop_r, drop_r;
  logic              out_valid_r;
  logic [FloorW-1:0] o_pos_r;
  logic [1:0]        o_head_r;
  logic [LoadW-1:0]  o_riders_r;
  logic              o_stop_r, o_drop_r;
  logic [TimeW-1:0]  o_time_r;

  lec_cmd_t                    cmd;
  logic [MAX_PASSENGERS:0]     empty_chain, board_chain;
  lec_interest_t               int_chain [MAX_PASSENGERS+1];
  logic [MAX_PASSENGERS-1:0]   alight_v, btgt_v, ride_v;
  logic [CntW-1:0]             n_alight;
  lec_interest_t               poi;
  logic [1:0]                  dir_new;
  logic                        in_fire, out_free;

  function automatic logic [FloorW-1:0] clamp_floor(input logic [FloorW-1:0] f);
    if (f == '0) return FloorW'(1);
    if (f > TopEff) return TopEff;
    return f;
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  // registers only change between items
  assign cfg_ch.ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = (in_ch.operation == OP_ADD) ? S_ADD : S_ALIGHT;
      S_ADD:    state_nxt = S_DONE;
      S_ALIGHT: state_nxt = S_BOARD;
      S_BOARD:  state_nxt = S_SCAN;
      S_SCAN:   state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // phase broadcast to the cells
  always_comb begin
    case (state_r)
      S_ADD:    phase = PH_ADD;
      S_ALIGHT: phase = PH_ALIGHT;
      S_BOARD:  phase = PH_BOARD;
      S_SCAN:   phase = PH_SCAN;
      default:  phase = PH_NONE;
    endcase
  end

  always_comb begin
    cmd.phase      = phase;
    cmd.floor      = floor_r;
    cmd.new_origin = org_r;
    cmd.new_target = tgt_r;
    cmd.can_board  = (load_r < cap_r);
  end

  // chain of cells: free-slot chain runs upward, boarding chain downward
  assign empty_chain[0]              = 1'b0;
  assign board_chain[MAX_PASSENGERS] = 1'b0;
  assign int_chain[0]                = '0;

  for (genvar i = 0; i < MAX_PASSENGERS; i++) begin : g_cell
    lec_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .empty_seen_in  (empty_chain[i]),
      .empty_seen_out (empty_chain[i+1]),
      .board_seen_in  (board_chain[i+1]),
      .board_seen_out (board_chain[i]),
      .interest_in    (int_chain[i]),
      .interest_out   (int_chain[i+1]),
      .alight         (alight_v[i]),
      .board_tgt_here (btgt_v[i]),
      .riding         (ride_v[i])
    );
  end

  assign n_alight = CntW'($countones(alight_v));
  assign poi      = int_chain[MAX_PASSENGERS];

  // LOOK rule
  always_comb begin
    dir_new = dir_r;
    if (!poi.above && !poi.below) begin
      if (!poi.here) dir_new = DIR_IDLE;
      else if (dir_r == DIR_IDLE) dir_new = DIR_UP;
    end else if (dir_r == DIR_DOWN) begin
      dir_new = poi.below ? DIR_DOWN : DIR_UP;
    end else begin
      dir_new = poi.above ? DIR_UP : DIR_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= LoadW'(4);
      floor_r     <= FloorW'(1);
      dir_r       <= DIR_IDLE;
      load_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_CAPACITY: cap_r   <= cfg_ch.data[LoadW-1:0];
          CFG_START:    floor_r <= clamp_floor(cfg_ch.data);
          default:      cap_r   <= cap_r;
        endcase
      end
      case (state_r)
        S_ALIGHT: begin
          // riders for this floor leave, load never below zero
          if (n_alight >= CntW'(load_r)) load_r <= '0;
          else load_r <= load_r - LoadW'(n_alight);
        end
        S_BOARD: begin
          if (cmd.can_board && board_chain[0] && !(|btgt_v)) load_r <= load_r + LoadW'(1);
        end
        S_SCAN: begin
          dir_r  <= dir_new;
          time_r <= time_r + TimeW'(1);
          if (poi.above || poi.below) begin
            if (dir_new == DIR_UP) begin
              if (floor_r < TopEff) floor_r <= floor_r + FloorW'(1);
            end else if (floor_r > FloorW'(1)) begin
              floor_r <= floor_r - FloorW'(1);
            end
          end
        end
        default: ;
      endcase
      out_valid_r <= ((state_r == S_DONE) && out_free) || (out_valid_r && !out_ch.ready);
    end
  end

  // item payload and flags
  always_ff @(posedge clk) begin
    if (in_fire) begin
      org_r  <= clamp_floor(in_ch.origin_floor);
      tgt_r  <= clamp_floor(in_ch.target_floor);
      stop_r <= 1'b0;
      drop_r <= 1'b0;
    end
    if (state_r == S_ADD) drop_r <= !empty_chain[MAX_PASSENGERS];
    if ((state_r == S_ALIGHT) && (|alight_v)) stop_r <= 1'b1;
    if ((state_r == S_BOARD) && cmd.can_board && board_chain[0]) stop_r <= 1'b1;
    if ((state_r == S_DONE) && out_free) begin
      o_pos_r    <= floor_r;
      o_head_r   <= dir_r;
      o_riders_r <= load_r;
      o_stop_r   <= stop_r;
      o_time_r   <= time_r;
      o_drop_r   <= drop_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.car_position    = o_pos_r;
  assign out_ch.heading         = o_head_r;
  assign out_ch.riders          = o_riders_r;
  assign out_ch.stopped_here    = o_stop_r;
  assign out_ch.time_units      = o_time_r;
  assign out_ch.request_dropped = o_drop_r;

`ifndef SYNTH
  a_load_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (CntW'(load_r) == CntW'($countones(ride_v))))
    else $error("load count differs from riding cells");
  a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (floor_r >= FloorW'(1)) && (floor_r <= TopEff))
    else $error("car outside floor range");
  a_heading_code: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r != 2'd3)
    else $error("bad heading code");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");
`endif

endmodule
`default_nettype wire
